// ===== rtl/nwb_pkg.sv =====
package nwb_pkg;

    localparam int EXP_W = 3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KIND   = 2'd2;
    localparam logic [1:0] REG_NONE   = 2'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic KIND_BOX = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAP,
        ST_DRAIN,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic acc;
        logic clr;
        logic load;
        logic step;
    } t_lane_ctl;

endpackage

// ===== rtl/normalized_window_blur_top.sv =====
// Normalised window blur of an RGB raster stream.
// Input beats (s_axis): tdata carries red, green, blue; tuser selects a pixel
// (0) or a flush (1). Output beats (m_axis): tdata carries the blurred pixel,
// tlast marks the final pixel of the frame.
// Configuration: write i_cfg_data to register i_cfg_idx (0 width, 1 height,
// 2 kernel kind) while the block is idle; a write to any of them restarts the frame.
// Output pixel p leaves when input pixel p + RADIUS*width + RADIUS arrives;
// the outputs still owed at frame end are drained by one flush beat each.
// A beat that yields a pixel passes through the states TAP (one line-store
// read per tap through the single read port), DRAIN, LOAD, DIV (a bit-serial
// divide of SUM_W steps in the three channel lanes) and DONE, which loads the
// output register; the next beat is accepted once the block is idle again.
// A beat that yields nothing leaves the block idle.
// One beat is in work at a time; the output register holds a finished pixel
// while the next beat is accepted, and the block waits in its last step while
// the receiver stalls with a pixel still held.
// Reset sets the default configuration and empties the output; the line
// store is not cleared, as only pixels of the current frame are read.
module normalized_window_blur_top #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic [0:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic        m_axis_tlast
);

    localparam int R     = KERNEL_SIZE / 2;
    localparam int D     = 2 * R * MAX_WIDTH + 2 * R + 1;
    localparam int AW    = $clog2(D);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = $clog2(MAX_WIDTH) + 16;
    localparam int TW    = $clog2(KERNEL_SIZE);
    localparam int NMAX  = KERNEL_SIZE * KERNEL_SIZE * (2 ** (R + 1));
    localparam int NW    = $clog2(NMAX + 1);
    localparam int SUM_W = NW + 8;
    localparam int DCW   = $clog2(SUM_W + 1);

    nwb_pkg::t_state r_state, n_state;
    nwb_pkg::t_lane_ctl lane_ctl;

    logic [10:0]    r_img_w;
    logic [15:0]    r_img_h;
    logic           r_kind;

    logic [PW-1:0]  r_in_pos;
    logic [WW-1:0]  r_in_col;
    logic [15:0]    r_in_row;
    logic [AW-1:0]  r_wptr;
    logic [PW-1:0]  r_out_pos;
    logic [WW-1:0]  r_out_col;
    logic [15:0]    r_out_row;
    logic [AW-1:0]  r_optr;

    logic [WW-1:0]  r_c_col;
    logic [15:0]    r_c_row;
    logic           r_c_last;
    logic [AW-1:0]  r_taddr;
    logic [TW-1:0]  r_ty, r_tx;
    logic           r_rv;
    logic [nwb_pkg::EXP_W-1:0] r_re;
    logic [NW-1:0]  r_n;
    logic [DCW-1:0] r_dcnt;

    logic [23:0]    mem [D];
    logic [23:0]    r_mem_q;

    logic           r_m_valid;
    logic [23:0]    r_m_data;
    logic           r_m_last;

    logic [WW-1:0]  w_eff;
    logic [15:0]    h_eff;
    logic [PW-1:0]  total, lag;
    logic [AW:0]    rs_sum, st_sum, step_sum;
    logic [AW-1:0]  row_step, start_addr, next_taddr;
    logic           in_done, s_fire, is_pix, pix_ok, pix_out, fl_ok, fl_last, start;
    logic           tap_last;
    logic signed [17:0] rr, cc;
    logic [TW-1:0]  ady, adx;
    logic [TW:0]    tap_dist;
    logic           tap_ok;
    logic [nwb_pkg::EXP_W-1:0] tap_exp;
    logic [NW-1:0]  dvs;
    logic [7:0]     q_r, q_g, q_b;
    logic           out_free;

    always_comb begin
        if (r_img_w == 11'd0) begin
            w_eff = WW'(1);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_img_w);
        end
        h_eff = (r_img_h == 16'd0) ? 16'd1 : r_img_h;
        total = PW'(w_eff) * PW'(h_eff);
        lag   = PW'(R) * PW'(w_eff) + PW'(R);

        rs_sum   = (AW+1)'(w_eff) + (AW+1)'(D - 2 * R);
        row_step = (rs_sum >= (AW+1)'(D)) ? AW'(rs_sum - (AW+1)'(D)) : AW'(rs_sum);
        st_sum   = (AW+1)'(r_optr) + (AW+1)'(D) - (AW+1)'(lag);
        start_addr = (st_sum >= (AW+1)'(D)) ? AW'(st_sum - (AW+1)'(D)) : AW'(st_sum);

        tap_last = (r_tx == TW'(KERNEL_SIZE - 1)) && (r_ty == TW'(KERNEL_SIZE - 1));
        step_sum = (r_tx == TW'(KERNEL_SIZE - 1)) ? (AW+1)'(r_taddr) + (AW+1)'(row_step)
                                                  : (AW+1)'(r_taddr) + (AW+1)'(1);
        next_taddr = (step_sum >= (AW+1)'(D)) ? AW'(step_sum - (AW+1)'(D)) : AW'(step_sum);

        in_done = r_in_row >= h_eff;
        s_fire  = s_axis_tvalid && s_axis_tready;
        is_pix  = s_axis_tuser[0] == nwb_pkg::OP_PIXEL;
        pix_ok  = is_pix && !in_done;
        pix_out = pix_ok && (r_in_pos >= lag);
        fl_ok   = (s_axis_tuser[0] == nwb_pkg::OP_FLUSH) && in_done && (r_out_pos < total);
        fl_last = (r_out_pos + PW'(1)) == total;
        start   = s_fire && (pix_out || fl_ok);

        rr  = 18'(r_c_row) + 18'(r_ty) - 18'(R);
        cc  = 18'(r_c_col) + 18'(r_tx) - 18'(R);
        ady = (r_ty >= TW'(R)) ? r_ty - TW'(R) : TW'(R) - r_ty;
        adx = (r_tx >= TW'(R)) ? r_tx - TW'(R) : TW'(R) - r_tx;
        tap_dist = (TW+1)'(ady) + (TW+1)'(adx);
        tap_ok = (rr >= 18'sd0) && (rr < $signed({2'b00, h_eff}))
              && (cc >= 18'sd0) && (cc < $signed(18'(w_eff)))
              && ((r_kind == nwb_pkg::KIND_BOX) || (32'(tap_dist) <= R + 1));
        tap_exp = (r_kind == nwb_pkg::KIND_BOX) ? '0
                : nwb_pkg::EXP_W'((TW+1)'(R + 1) - tap_dist);

        dvs = (r_n == '0) ? NW'(1) : r_n;
        out_free = !r_m_valid || m_axis_tready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nwb_pkg::ST_IDLE:  if (start) n_state = nwb_pkg::ST_TAP;
            nwb_pkg::ST_TAP:   if (tap_last) n_state = nwb_pkg::ST_DRAIN;
            nwb_pkg::ST_DRAIN: n_state = nwb_pkg::ST_LOAD;
            nwb_pkg::ST_LOAD:  n_state = nwb_pkg::ST_DIV;
            nwb_pkg::ST_DIV:   if (r_dcnt == DCW'(SUM_W - 1)) n_state = nwb_pkg::ST_DONE;
            nwb_pkg::ST_DONE:  if (out_free) n_state = nwb_pkg::ST_IDLE;
            default:           n_state = nwb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = r_state == nwb_pkg::ST_IDLE;
        lane_ctl.clr  = r_state == nwb_pkg::ST_IDLE;
        lane_ctl.acc  = r_rv;
        lane_ctl.load = r_state == nwb_pkg::ST_LOAD;
        lane_ctl.step = r_state == nwb_pkg::ST_DIV;
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && pix_ok) begin
            mem[r_wptr] <= s_axis_tdata;
        end
        r_mem_q <= mem[r_taddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == nwb_pkg::ST_IDLE) begin
            r_n <= '0;
        end else if (r_rv) begin
            r_n <= r_n + (NW'(1) << r_re);
        end
        r_re <= tap_exp;
        if (start) begin
            r_c_row  <= r_out_row;
            r_c_col  <= r_out_col;
            r_c_last <= fl_ok && fl_last;
            r_taddr  <= start_addr;
            r_ty     <= '0;
            r_tx     <= '0;
        end else if (r_state == nwb_pkg::ST_TAP) begin
            r_taddr <= next_taddr;
            if (r_tx == TW'(KERNEL_SIZE - 1)) begin
                r_tx <= '0;
                r_ty <= r_ty + TW'(1);
            end else begin
                r_tx <= r_tx + TW'(1);
            end
        end
        if (r_state == nwb_pkg::ST_LOAD) begin
            r_dcnt <= '0;
        end else if (r_state == nwb_pkg::ST_DIV) begin
            r_dcnt <= r_dcnt + DCW'(1);
        end
        if (r_state == nwb_pkg::ST_DONE && out_free) begin
            r_m_data <= {q_b, q_g, q_r};
            r_m_last <= r_c_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nwb_pkg::ST_IDLE;
            r_img_w   <= 11'd640;
            r_img_h   <= 16'd480;
            r_kind    <= nwb_pkg::KIND_BOX;
            r_in_pos  <= '0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_wptr    <= '0;
            r_out_pos <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_optr    <= '0;
            r_rv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= (r_state == nwb_pkg::ST_TAP) && tap_ok;

            if (s_fire && pix_ok) begin
                r_in_pos <= r_in_pos + PW'(1);
                r_wptr   <= (r_wptr == AW'(D - 1)) ? '0 : r_wptr + AW'(1);
                if (r_in_col == w_eff - WW'(1)) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 16'd1;
                end else begin
                    r_in_col <= r_in_col + WW'(1);
                end
            end

            if (start) begin
                if (fl_ok && fl_last) begin
                    // frame end: start over
                    r_in_pos  <= '0;
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_wptr    <= '0;
                    r_out_pos <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                    r_optr    <= '0;
                end else begin
                    r_out_pos <= r_out_pos + PW'(1);
                    r_optr    <= (r_optr == AW'(D - 1)) ? '0 : r_optr + AW'(1);
                    if (r_out_col == w_eff - WW'(1)) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 16'd1;
                    end else begin
                        r_out_col <= r_out_col + WW'(1);
                    end
                end
            end

            if (r_state == nwb_pkg::ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (i_cfg_wr_en && i_cfg_idx != nwb_pkg::REG_NONE) begin
                unique case (i_cfg_idx)
                    nwb_pkg::REG_WIDTH:  r_img_w <= i_cfg_data[10:0];
                    nwb_pkg::REG_HEIGHT: r_img_h <= i_cfg_data;
                    nwb_pkg::REG_KIND:   r_kind  <= i_cfg_data[0];
                    default:             r_kind  <= r_kind;
                endcase
                r_in_pos  <= '0;
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_wptr    <= '0;
                r_out_pos <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_optr    <= '0;
            end
        end
    end

    nwb_lane #(.NW(NW), .SUM_W(SUM_W)) u_lane_r (
        .i_clk (i_clk), .i_ctl (lane_ctl), .i_exp (r_re),
        .i_px  (r_mem_q[7:0]), .i_dvs (dvs), .o_quo (q_r)
    );

    nwb_lane #(.NW(NW), .SUM_W(SUM_W)) u_lane_g (
        .i_clk (i_clk), .i_ctl (lane_ctl), .i_exp (r_re),
        .i_px  (r_mem_q[15:8]), .i_dvs (dvs), .o_quo (q_g)
    );

    nwb_lane #(.NW(NW), .SUM_W(SUM_W)) u_lane_b (
        .i_clk (i_clk), .i_ctl (lane_ctl), .i_exp (r_re),
        .i_px  (r_mem_q[23:16]), .i_dvs (dvs), .o_quo (q_b)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

// ===== rtl/nwb_lane.sv =====
module nwb_lane #(
    parameter int NW    = 8,
    parameter int SUM_W = 16
) (
    input  logic                     i_clk,
    input  nwb_pkg::t_lane_ctl       i_ctl,
    input  logic [nwb_pkg::EXP_W-1:0] i_exp,
    input  logic [7:0]               i_px,
    input  logic [NW-1:0]            i_dvs,
    output logic [7:0]               o_quo
);

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_quo;
    logic [NW-1:0]    r_rem;
    logic [NW:0]      cand;
    logic             fits;

    always_comb begin
        cand = {r_rem, r_quo[SUM_W-1]};
        fits = cand >= {1'b0, i_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + (SUM_W'(i_px) << i_exp);
        end
        if (i_ctl.load) begin
            r_quo <= r_sum;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            // restoring step: one quotient bit per cycle
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? NW'(cand - {1'b0, i_dvs}) : NW'(cand);
        end
    end

    assign o_quo = r_quo[7:0];

endmodule

// ===== rtl/nwb_chk.sv =====
module nwb_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("output beat appeared straight after an input beat");

endmodule

bind normalized_window_blur_top nwb_chk u_nwb_chk (.*);
